### rtl/core/spot_light_box_intensity_unit_defines.svh
// Assertion macros shared by the spotlight intensity checkers.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef SPOT_LIGHT_BOX_INTENSITY_UNIT_DEFINES_SVH
`define SPOT_LIGHT_BOX_INTENSITY_UNIT_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define SLBI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define SLBI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/slbi_pkg.sv
// Types and constants for the spotlight box intensity unit.
// No dependencies.
package slbi_pkg;

	typedef struct packed {
		logic signed [31:0] light_x;
		logic signed [31:0] light_y;
		logic signed [31:0] light_z;
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_min_y;
		logic signed [31:0] box_min_z;
		logic signed [31:0] box_max_x;
		logic signed [31:0] box_max_y;
		logic signed [31:0] box_max_z;
	} req_t;

	typedef struct packed {
		logic [15:0] intensity;
		logic        beyond_radius;
		logic        saturated;
	} rsp_t;

	typedef enum logic [2:0] {
		CFG_COLOR       = 3'd0,
		CFG_RADIUS      = 3'd1,
		CFG_KNEE        = 3'd2,
		CFG_KNEE_VAL    = 3'd3,
		CFG_POINT_SHARE = 3'd4,
		CFG_CONE_COS    = 3'd5,
		CFG_BEAM_DIR    = 3'd6
	} cfg_idx_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	localparam logic [47:0]        RST_COLOR       = 48'h8000_8000_8000;
	localparam logic [30:0]        RST_RADIUS      = 31'd5242880;
	localparam logic [30:0]        RST_KNEE        = 31'd1310720;
	localparam logic [15:0]        RST_KNEE_VAL    = 16'd16384;
	localparam logic [15:0]        RST_POINT_SHARE = 16'd983;
	localparam logic signed [15:0] RST_CONE_COS    = 16'sd0;
	localparam logic [47:0]        RST_BEAM_DIR    = 48'h0000_C000_0000;

	localparam logic [15:0] ONE_Q15    = 16'd32768;
	localparam logic [20:0] FACTOR_MAX = 21'h10_0000;
	localparam logic [12:0] LUMA_R     = 13'd6963;
	localparam logic [14:0] LUMA_G     = 15'd23442;
	localparam logic [11:0] LUMA_B     = 12'd2363;

endpackage

### rtl/core/spot_light_box_intensity_unit.sv
// Spotlight intensity on an axis-aligned box: fixed-point pipeline top level.
// Uses slbi_pkg, slbi_isqrt_pipe and slbi_div_pipe.
//
// One item enters per clock while the pipeline is not frozen. The pipeline
// is made of the bit-per-stage units in the path: a 31-stage square
// root for the distance, an 18-stage divider pair for the falloff fraction
// and the cone cosine, and a 21-stage divider for the cone factor, plus ten
// stages of clamping, multiplying and summing and the output register. Back
// pressure freezes the whole pipeline only when its last stage holds an item
// and the output register is full and not taken; otherwise bubbles keep
// draining and new items keep being accepted. Configuration registers are
// plain flops, written by index; write them only while no item is in flight.
// The radius square is registered from the radius register and the color
// luminance from registered channel products.
module spot_light_box_intensity_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  slbi_pkg::req_t                    req,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output slbi_pkg::rsp_t                    rsp,
	input  logic                              cfg_we,
	input  logic [slbi_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [slbi_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// ---------------- configuration ----------------
	logic [47:0]        color_q;
	logic [30:0]        radius_q;
	logic [30:0]        knee_q;
	logic [15:0]        kval_q;
	logic [15:0]        pshare_q;
	logic signed [15:0] cone_q;
	logic [47:0]        beam_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q  <= slbi_pkg::RST_COLOR;
			radius_q <= slbi_pkg::RST_RADIUS;
			knee_q   <= slbi_pkg::RST_KNEE;
			kval_q   <= slbi_pkg::RST_KNEE_VAL;
			pshare_q <= slbi_pkg::RST_POINT_SHARE;
			cone_q   <= slbi_pkg::RST_CONE_COS;
			beam_q   <= slbi_pkg::RST_BEAM_DIR;
		end else if (cfg_we) begin
			unique case (slbi_pkg::cfg_idx_t'(cfg_idx))
				slbi_pkg::CFG_COLOR:       color_q  <= cfg_data;
				slbi_pkg::CFG_RADIUS:      radius_q <= cfg_data[30:0];
				slbi_pkg::CFG_KNEE:        knee_q   <= cfg_data[30:0];
				slbi_pkg::CFG_KNEE_VAL:    kval_q   <= cfg_data[15:0];
				slbi_pkg::CFG_POINT_SHARE: pshare_q <= cfg_data[15:0];
				slbi_pkg::CFG_CONE_COS:    cone_q   <= $signed(cfg_data[15:0]);
				slbi_pkg::CFG_BEAM_DIR:    beam_q   <= cfg_data;
				default: ; // index past the register list: ignored
			endcase
		end
	end

	// Fractions above 1.0 are clamped and flagged on every result within the radius.
	logic [15:0] kv_eff;
	logic [15:0] ps_eff;
	logic        cfg_sat;

	assign kv_eff  = (kval_q > slbi_pkg::ONE_Q15) ? slbi_pkg::ONE_Q15 : kval_q;
	assign ps_eff  = (pshare_q > slbi_pkg::ONE_Q15) ? slbi_pkg::ONE_Q15 : pshare_q;
	assign cfg_sat = (kval_q > slbi_pkg::ONE_Q15) || (pshare_q > slbi_pkg::ONE_Q15);

	// Derived config: radius squared, luminance (products, then sum).
	logic [61:0] rsq_q;
	logic [28:0] lum_r_q;
	logic [30:0] lum_g_q;
	logic [27:0] lum_b_q;
	logic [15:0] lum_q;

	always_ff @(posedge clk) begin
		rsq_q   <= 62'(radius_q) * 62'(radius_q);
		lum_r_q <= 29'(color_q[47:32]) * 29'(slbi_pkg::LUMA_R);
		lum_g_q <= 31'(color_q[31:16]) * 31'(slbi_pkg::LUMA_G);
		lum_b_q <= 28'(color_q[15:0]) * 28'(slbi_pkg::LUMA_B);
		lum_q   <= 16'((32'(lum_r_q) + 32'(lum_g_q) + 32'(lum_b_q)) >> 15);
	end

	// ---------------- flow control ----------------
	// Advance unless the tail item has nowhere to go.
	logic en;
	logic v_s11;

	assign en        = rsp_ready || !rsp_valid || !v_s11;
	assign req_ready = en;

	// ---------------- S1: clamp into box, offset from nearest point ----------------
	logic signed [31:0] p_ax  [3];
	logic signed [31:0] lo_ax [3];
	logic signed [31:0] hi_ax [3];
	logic signed [31:0] cl_ax [3];
	logic signed [32:0] d_s1  [3];
	logic               v_s1;

	assign p_ax[0]  = req.light_x;
	assign p_ax[1]  = req.light_y;
	assign p_ax[2]  = req.light_z;
	assign lo_ax[0] = req.box_min_x;
	assign lo_ax[1] = req.box_min_y;
	assign lo_ax[2] = req.box_min_z;
	assign hi_ax[0] = req.box_max_x;
	assign hi_ax[1] = req.box_max_y;
	assign hi_ax[2] = req.box_max_z;

	// min tested first, so an inverted box still resolves deterministically
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (p_ax[i] < lo_ax[i]) begin
				cl_ax[i] = lo_ax[i];
			end else if (p_ax[i] > hi_ax[i]) begin
				cl_ax[i] = hi_ax[i];
			end else begin
				cl_ax[i] = p_ax[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= 33'(p_ax[i]) - 33'(cl_ax[i]);
			end
		end
	end

	// ---------------- S2: magnitudes, per-axis radius test ----------------
	logic [32:0]        mag_ax [3];
	logic [30:0]        mag_s2 [3];
	logic signed [31:0] d_s2   [3];
	logic               beyond_s2;
	logic               v_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_ax[i] = d_s1[i][32] ? 33'(-d_s1[i]) : 33'(d_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s2[i] <= mag_ax[i][30:0];
				d_s2[i]   <= d_s1[i][31:0];
			end
			beyond_s2 <= (mag_ax[0] >= 33'(radius_q)) || (mag_ax[1] >= 33'(radius_q))
				|| (mag_ax[2] >= 33'(radius_q));
		end
	end

	// ---------------- S3: squares and direction products ----------------
	// Past this point axis values are exact only for items still in range.
	logic signed [15:0] u_ax  [3];
	logic [61:0]        sq_s3 [3];
	logic signed [47:0] pr_s3 [3];
	logic               beyond_s3;
	logic               v_s3;

	assign u_ax[0] = $signed(beam_q[47:32]);
	assign u_ax[1] = $signed(beam_q[31:16]);
	assign u_ax[2] = $signed(beam_q[15:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= 62'(mag_s2[i]) * 62'(mag_s2[i]);
				pr_s3[i] <= 48'(d_s2[i]) * 48'(u_ax[i]);
			end
			beyond_s3 <= beyond_s2;
		end
	end

	// ---------------- S4: squared distance, dot product, radius test ----------------
	logic [63:0]        sum_nx;
	logic [63:0]        sum_s4;
	logic signed [49:0] dot_s4;
	logic               beyond_s4;
	logic               v_s4;

	assign sum_nx = 64'(sq_s3[0]) + 64'(sq_s3[1]) + 64'(sq_s3[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4    <= sum_nx;
			dot_s4    <= 50'(pr_s3[0]) + 50'(pr_s3[1]) + 50'(pr_s3[2]);
			beyond_s4 <= beyond_s3 || (sum_nx >= 64'(rsq_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// ---------------- distance: square root ----------------
	logic        sqr_v;
	logic [30:0] root_len;
	logic [50:0] sqr_sb;

	slbi_isqrt_pipe #(
		.XW   (64),
		.SB_W (51)
	) u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s4),
		.x      (sum_s4),
		.sb_in  ({beyond_s4, dot_s4}),
		.out_v  (sqr_v),
		.root   (root_len),
		.sb_out (sqr_sb)
	);

	// ---------------- S5 (comb): falloff fraction and cone cosine dividers ----------------
	logic               beyond_5;
	logic signed [49:0] dot_5;
	logic [49:0]        dot_mag;
	logic               near_5;
	logic               kz_5;
	logic               zd_5;
	logic [30:0]        dk_5;
	logic [48:0]        qnum;
	logic [30:0]        qden;
	logic [48:0]        anum;
	logic [30:0]        aden;

	assign beyond_5 = sqr_sb[50];
	assign dot_5    = $signed(sqr_sb[49:0]);
	assign dot_mag  = dot_5[49] ? 50'(-dot_5) : 50'(dot_5);
	assign near_5   = root_len <= knee_q;
	assign kz_5     = knee_q == 31'd0;
	assign zd_5     = root_len == 31'd0;
	assign dk_5     = root_len - knee_q;

	// near: root_len / knee; far: (root_len - knee) / (radius - knee), both Q.15
	assign qnum = near_5 ? 49'({root_len, 15'd0}) : 49'({dk_5, 15'd0});
	assign qden = near_5 ? (kz_5 ? 31'd1 : knee_q) : (radius_q - knee_q);
	// cone cosine: 2 * |dot| / root_len, sign applied afterwards
	assign anum = {dot_mag[47:0], 1'b0};
	assign aden = zd_5 ? 31'd1 : root_len;

	logic        qd_v;
	logic [17:0] qquo;
	logic [1:0]  qd_sb;
	logic [17:0] aquo;
	logic [2:0]  ad_sb;

	slbi_div_pipe #(
		.NUM_W (49),
		.DEN_W (31),
		.Q_W   (18),
		.SB_W  (2)
	) u_qdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (sqr_v),
		.num    (qnum),
		.den    (qden),
		.sb_in  ({near_5, kz_5}),
		.out_v  (qd_v),
		.quo    (qquo),
		.sb_out (qd_sb)
	);

	slbi_div_pipe #(
		.NUM_W (49),
		.DEN_W (31),
		.Q_W   (18),
		.SB_W  (3)
	) u_adiv (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (sqr_v),
		.num    (anum),
		.den    (aden),
		.sb_in  ({beyond_5, dot_5[49], zd_5}),
		.out_v  (),
		.quo    (aquo),
		.sb_out (ad_sb)
	);

	// ---------------- S6: falloff value t, cone numerator ----------------
	logic               near_6;
	logic               kz_6;
	logic [15:0]        q16;
	logic [15:0]        tm_a;
	logic [31:0]        t_prod;
	logic signed [18:0] a19;
	logic [15:0]        t_s6;
	logic signed [19:0] num_s6;
	logic               sat_s6;
	logic               beyond_s6;
	logic               v_s6;

	assign near_6 = qd_sb[1];
	assign kz_6   = qd_sb[0];
	// knee at zero with zero distance: fraction pinned at 1.0
	assign q16    = (near_6 && kz_6) ? slbi_pkg::ONE_Q15 : qquo[15:0];
	assign tm_a   = near_6 ? slbi_pkg::ONE_Q15 - kv_eff : kv_eff;
	assign t_prod = 32'(tm_a) * 32'(q16);
	// zero distance: direction undefined, cosine taken as zero
	assign a19    = ad_sb[0] ? 19'sd0 : (ad_sb[1] ? -$signed({1'b0, aquo})
		: $signed({1'b0, aquo}));

	always_ff @(posedge clk) begin
		if (en) begin
			t_s6      <= near_6 ? slbi_pkg::ONE_Q15 - 16'(t_prod >> 15)
				: kv_eff - 16'(t_prod >> 15);
			num_s6    <= 20'(cone_q) - 20'(a19);
			sat_s6    <= (near_6 && kz_6) || ad_sb[0];
			beyond_s6 <= ad_sb[2];
		end
	end

	// ---------------- S7: cone factor setup ----------------
	logic        cz;
	logic        nneg;
	logic        mism;
	logic [19:0] nmag;
	logic [15:0] cmag;
	logic [34:0] fnum;
	logic [36:0] flim;
	logic        fovf;
	logic        ovr;
	logic        big;

	assign cz   = cone_q == 16'sd0;
	assign nneg = num_s6[19];
	assign mism = (num_s6 == 20'sd0) || (nneg != cone_q[15]);
	assign nmag = nneg ? 20'(-num_s6) : 20'(num_s6);
	assign cmag = cone_q[15] ? 16'(-cone_q) : 16'(cone_q);
	assign fnum = {nmag[19:0], 15'd0};
	// factor above 32.0 <=> fnum >= (2**20 + 1) * |c|
	assign flim = {1'b0, cmag, 20'd0} + 37'(cmag);
	assign fovf = 37'(fnum) >= flim;
	// zero cone cosine: factor is full scale when the numerator is positive
	assign ovr  = cz || mism || fovf;
	assign big  = cz ? (!nneg && (num_s6 != 20'sd0)) : (!mism && fovf);

	logic [34:0] fnum_s7;
	logic [15:0] fden_s7;
	logic [15:0] t_s7;
	logic        ovr_s7;
	logic        big_s7;
	logic        sat_s7;
	logic        beyond_s7;
	logic        v_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			fnum_s7   <= ovr ? 35'd0 : fnum;
			fden_s7   <= ovr ? 16'd1 : cmag;
			t_s7      <= t_s6;
			ovr_s7    <= ovr;
			big_s7    <= big;
			sat_s7    <= sat_s6 || cz || (!mism && fovf);
			beyond_s7 <= beyond_s6;
		end
	end

	logic        fd_v;
	logic [20:0] fquo;
	logic [19:0] fd_sb;

	slbi_div_pipe #(
		.NUM_W (35),
		.DEN_W (16),
		.Q_W   (21),
		.SB_W  (20)
	) u_fdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s7),
		.num    (fnum_s7),
		.den    (fden_s7),
		.sb_in  ({t_s7, ovr_s7, big_s7, sat_s7, beyond_s7}),
		.out_v  (fd_v),
		.quo    (fquo),
		.sb_out (fd_sb)
	);

	// ---------------- S8: factor, point and spot weights ----------------
	logic [15:0] t_8;
	logic [20:0] f_s8;
	logic [31:0] p1_s8;
	logic [31:0] p2_s8;
	logic        sat_s8;
	logic        beyond_s8;
	logic        v_s8;

	assign t_8 = fd_sb[19:4];

	always_ff @(posedge clk) begin
		if (en) begin
			f_s8      <= fd_sb[3] ? (fd_sb[2] ? slbi_pkg::FACTOR_MAX : 21'd0) : fquo;
			p1_s8     <= 32'(slbi_pkg::ONE_Q15 - ps_eff) * 32'(t_8);
			p2_s8     <= 32'(ps_eff) * 32'(t_8);
			sat_s8    <= fd_sb[1];
			beyond_s8 <= fd_sb[0];
		end
	end

	// ---------------- S9: spot share times cone factor ----------------
	logic [36:0] direct_s9;
	logic [15:0] p2h_s9;
	logic        sat_s9;
	logic        beyond_s9;
	logic        v_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			direct_s9 <= 37'(p1_s8[30:15]) * 37'(f_s8);
			p2h_s9    <= p2_s8[30:15];
			sat_s9    <= sat_s8;
			beyond_s9 <= beyond_s8;
		end
	end

	// ---------------- S10: total share ----------------
	logic [21:0] s_s10;
	logic        sat_s10;
	logic        beyond_s10;
	logic        v_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			s_s10      <= 22'(p2h_s9) + 22'(direct_s9 >> 15);
			sat_s10    <= sat_s9;
			beyond_s10 <= beyond_s9;
		end
	end

	// ---------------- S11: luminance weighting ----------------
	logic [37:0] prod_s11;
	logic        sat_s11;
	logic        beyond_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s11   <= 38'(lum_q) * 38'(s_s10);
			sat_s11    <= sat_s10;
			beyond_s11 <= beyond_s10;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s6  <= qd_v;
			v_s7  <= v_s6;
			v_s8  <= fd_v;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	// ---------------- output register: Q4.12 with saturation ----------------
	logic [19:0] ihi;
	logic        clip;

	assign ihi  = prod_s11[37:18];
	assign clip = |ihi[19:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (rsp_ready || !rsp_valid) begin
			rsp_valid <= v_s11;
		end
	end

	// beyond radius: zero intensity, no saturation report
	always_ff @(posedge clk) begin
		if (rsp_ready || !rsp_valid) begin
			rsp.beyond_radius <= beyond_s11;
			rsp.intensity     <= beyond_s11 ? 16'd0 : (clip ? 16'hFFFF : ihi[15:0]);
			rsp.saturated     <= !beyond_s11 && (sat_s11 || clip || cfg_sat);
		end
	end

endmodule

### rtl/core/slbi_div_pipe.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Standalone; carries a sideband word alongside the operands.
module slbi_div_pipe #(
	parameter int NUM_W = 49,
	parameter int DEN_W = 31,
	parameter int Q_W   = 18,
	parameter int SB_W  = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_v,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [SB_W-1:0]  sb_in,
	output logic             out_v,
	output logic [Q_W-1:0]   quo,
	output logic [SB_W-1:0]  sb_out
);

	// quotient must fit in Q_W bits: num < den << Q_W
	localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

	logic [CW-1:0]    rem_s [1:Q_W];
	logic [DEN_W-1:0] den_s [1:Q_W];
	logic [Q_W-1:0]   quo_s [1:Q_W];
	logic [SB_W-1:0]  sb_s  [1:Q_W];
	logic             v_s   [1:Q_W];

	genvar k;
	for (k = 0; k < Q_W; k++) begin : g_stage
		logic [CW-1:0]    cur_rem;
		logic [CW-1:0]    sh;
		logic [DEN_W-1:0] cur_den;
		logic [Q_W-1:0]   cur_quo;
		logic [SB_W-1:0]  cur_sb;
		logic             cur_v;
		logic             ge;

		if (k == 0) begin : g_head
			assign cur_rem = CW'(num);
			assign cur_den = den;
			assign cur_quo = '0;
			assign cur_sb  = sb_in;
			assign cur_v   = in_v;
		end else begin : g_body
			assign cur_rem = rem_s[k];
			assign cur_den = den_s[k];
			assign cur_quo = quo_s[k];
			assign cur_sb  = sb_s[k];
			assign cur_v   = v_s[k];
		end

		assign sh = CW'(cur_den) << (Q_W - 1 - k);
		assign ge = cur_rem >= sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? cur_rem - sh : cur_rem;
				den_s[k+1] <= cur_den;
				quo_s[k+1] <= {cur_quo[Q_W-2:0], ge};
				sb_s[k+1]  <= cur_sb;
			end
		end
	end

	assign out_v  = v_s[Q_W];
	assign quo    = quo_s[Q_W];
	assign sb_out = sb_s[Q_W];

endmodule

### rtl/core/slbi_isqrt_pipe.sv
// Pipelined integer square root, one root bit per stage.
// Standalone; input must stay below 2**(XW-2) for an exact floor root.
module slbi_isqrt_pipe #(
	parameter int XW   = 64,
	parameter int SB_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  logic [XW-1:0]     x,
	input  logic [SB_W-1:0]   sb_in,
	output logic              out_v,
	output logic [XW/2-2:0]   root,
	output logic [SB_W-1:0]   sb_out
);

	localparam int STEPS = XW / 2 - 1;

	logic [XW-1:0]   x_s  [1:STEPS];
	logic [XW-1:0]   r_s  [1:STEPS];
	logic [SB_W-1:0] sb_s [1:STEPS];
	logic            v_s  [1:STEPS];

	genvar k;
	for (k = 0; k < STEPS; k++) begin : g_stage
		localparam logic [XW-1:0] B = {{(XW-1){1'b0}}, 1'b1} << (2 * (STEPS - 1 - k));
		logic [XW-1:0]   cur_x;
		logic [XW-1:0]   cur_r;
		logic [XW-1:0]   rb;
		logic [SB_W-1:0] cur_sb;
		logic            cur_v;
		logic            ge;

		if (k == 0) begin : g_head
			assign cur_x  = x;
			assign cur_r  = '0;
			assign cur_sb = sb_in;
			assign cur_v  = in_v;
		end else begin : g_body
			assign cur_x  = x_s[k];
			assign cur_r  = r_s[k];
			assign cur_sb = sb_s[k];
			assign cur_v  = v_s[k];
		end

		assign rb = cur_r + B;
		assign ge = cur_x >= rb;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k+1]  <= ge ? cur_x - rb : cur_x;
				r_s[k+1]  <= ge ? (cur_r >> 1) + B : cur_r >> 1;
				sb_s[k+1] <= cur_sb;
			end
		end
	end

	assign out_v  = v_s[STEPS];
	assign root   = r_s[STEPS][XW/2-2:0];
	assign sb_out = sb_s[STEPS];

endmodule

### rtl/core/slbi_checker.sv
// Port-level checker for the spotlight intensity unit, bound to the top level.
// Uses slbi_pkg and the assertion macros header.
`include "spot_light_box_intensity_unit_defines.svh"

module slbi_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_ready,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input slbi_pkg::rsp_t                    rsp
);

	// out-of-range items carry no light and no saturation
	`SLBI_ASSERT_NOW(a_beyond_dark, rsp_valid && rsp.beyond_radius, rsp.intensity == 16'd0 && !rsp.saturated, "beyond-radius item not dark")

	// a draining output never blocks the input side
	`SLBI_ASSERT_NOW(a_flow_through, rsp_ready, req_ready, "input stalled while output drains")

	// a waiting result item holds
	`SLBI_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result item changed while stalled")

endmodule

bind spot_light_box_intensity_unit slbi_checker u_slbi_checker (.*);
